/* hdl/ssi_encoder_frame_checker_macros.svh */
// ----------------------------------------------------------------------------
// ssi_encoder_frame_checker_macros.svh
// Assertion macros for the SSI encoder frame checker.
// ----------------------------------------------------------------------------
`ifndef SSI_ENCODER_FRAME_CHECKER_MACROS_SVH
`define SSI_ENCODER_FRAME_CHECKER_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/ssiefc_pkg.sv */
// ----------------------------------------------------------------------------
// ssiefc_pkg
// Types and constants of the SSI encoder frame checker.
// ----------------------------------------------------------------------------
package ssiefc_pkg;

	localparam int CH_W      = 3;
	localparam int MAX_ENC   = 8;
	localparam int FRAME_W   = 24;
	localparam int WORD_W    = 18;
	localparam int POS_W     = 12;
	localparam int STAT_W    = 6;
	localparam int CNT_W     = 16;
	localparam int MAP_W     = MAX_ENC * CH_W;
	localparam int OUT_W     = 64;
	localparam int DATA_W    = 2 * CH_W + POS_W + STAT_W + 2 * CNT_W + CH_W;

	localparam logic [MAP_W-1:0]  SELECT_MAP_RST = 24'd16434768;
	localparam logic [CNT_W-1:0]  CNT_MAX        = '1;
	localparam logic [STAT_W-1:0] STAT_ALL_ONES  = 6'h3F;
	localparam logic [STAT_W-1:0] STAT_ALARM     = 6'h18;
	localparam logic [STAT_W-1:0] STAT_MAG       = 6'h06;
	localparam logic [STAT_W-1:0] STAT_COMP      = 6'h20;

	typedef enum logic [2:0] {
		RC_OK        = 3'd0,
		RC_NOT_READY = 3'd1,
		RC_ALARM     = 3'd2,
		RC_MAGNITUDE = 3'd3,
		RC_PARITY    = 3'd4,
		RC_NOT_COMP  = 3'd5
	} result_code_t;

endpackage

/* hdl/ssi_encoder_frame_checker.sv */
// ----------------------------------------------------------------------------
// ssi_encoder_frame_checker
// Decodes and checks round-robin SSI encoder frames, keeps per-channel state.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one 24-bit received frame per transaction (tdata[23:0]).
//   m_axis: one result per frame, tdata from bit 0 up: channel, result_code,
//     position, status_bits, error_count, max_error_count, next_select.
//   cfg: write of the select_map register, taken in any cycle (cfg_ready = 1);
//     write only while no frame is in flight.
//   Path: an accepted frame passes the input register, then the result
//     register, which drives m_axis.
//   Throughput: one frame per cycle while m_tready stays high; per-channel counters update in the same
//     cycle the result register loads, so back-to-back frames see fresh state.
//   Stall: while m_tready is low, the result holds and one more frame may sit
//     in the input register; s_tready then drops.
//   Reset: channel counter and all per-channel state clear to zero,
//     select_map returns to its default map.
// ----------------------------------------------------------------------------
`include "ssi_encoder_frame_checker_macros.svh"

module ssi_encoder_frame_checker #(
	parameter int NUM_ENCODERS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ssiefc_pkg::FRAME_W-1:0]  s_tdata,   // raw_frame
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// channel, result_code, position, status_bits, error_count,
	// max_error_count, next_select, zero pad
	output logic [ssiefc_pkg::OUT_W-1:0]    m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ssiefc_pkg::MAP_W-1:0]    cfg_data   // select_map
);

	localparam int IDX_W = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;
	localparam logic [ssiefc_pkg::CH_W-1:0] LAST_CH = ssiefc_pkg::CH_W'(NUM_ENCODERS - 1);

	logic [ssiefc_pkg::MAP_W-1:0]   select_map_q;
	logic [ssiefc_pkg::CH_W-1:0]    chan_q;
	logic [ssiefc_pkg::POS_W-1:0]   pos_q  [NUM_ENCODERS];
	logic [ssiefc_pkg::STAT_W-1:0]  stat_q [NUM_ENCODERS];
	logic [ssiefc_pkg::CNT_W-1:0]   err_q  [NUM_ENCODERS];
	logic [ssiefc_pkg::CNT_W-1:0]   peak_q [NUM_ENCODERS];

	logic                           valid_s1;
	logic [ssiefc_pkg::FRAME_W-1:0] frame_s1;
	logic                           out_valid_q;
	logic [ssiefc_pkg::OUT_W-1:0]   out_data_q;

	logic                           out_free;
	logic                           advance;
	logic [IDX_W-1:0]               idx;
	logic [ssiefc_pkg::CH_W-1:0]    chan_nxt;
	logic [ssiefc_pkg::WORD_W-1:0]  word;
	logic [ssiefc_pkg::STAT_W-1:0]  stat;
	ssiefc_pkg::result_code_t       code;
	logic [ssiefc_pkg::CNT_W-1:0]   err_nxt;
	logic [ssiefc_pkg::CNT_W-1:0]   peak_nxt;
	logic [ssiefc_pkg::POS_W-1:0]   pos_nxt;
	logic [ssiefc_pkg::STAT_W-1:0]  stat_nxt;
	logic [ssiefc_pkg::CH_W-1:0]    sel_nxt;

	assign out_free  = !out_valid_q || m_tready;
	assign advance   = valid_s1 && out_free;
	assign s_tready  = !valid_s1 || out_free;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	assign idx      = chan_q[IDX_W-1:0];
	assign chan_nxt = (chan_q >= LAST_CH) ? '0 : chan_q + 1'b1;
	assign sel_nxt  = select_map_q[ssiefc_pkg::CH_W * chan_nxt +: ssiefc_pkg::CH_W];
	assign word     = frame_s1[ssiefc_pkg::FRAME_W-2:5];
	assign stat     = word[ssiefc_pkg::STAT_W-1:0];

	always_comb begin
		if (stat == ssiefc_pkg::STAT_ALL_ONES || stat == '0) begin
			code = ssiefc_pkg::RC_NOT_READY;
		end else if ((stat & ssiefc_pkg::STAT_ALARM) != '0) begin
			code = ssiefc_pkg::RC_ALARM;
		end else if ((stat & ssiefc_pkg::STAT_MAG) == ssiefc_pkg::STAT_MAG) begin
			code = ssiefc_pkg::RC_MAGNITUDE;
		end else if (^word) begin
			code = ssiefc_pkg::RC_PARITY;
		end else if ((stat & ssiefc_pkg::STAT_COMP) == '0) begin
			code = ssiefc_pkg::RC_NOT_COMP;
		end else begin
			code = ssiefc_pkg::RC_OK;
		end
	end

	always_comb begin
		if (code == ssiefc_pkg::RC_OK) begin
			pos_nxt  = word[ssiefc_pkg::WORD_W-1:ssiefc_pkg::STAT_W];
			stat_nxt = stat;
			err_nxt  = '0;
			peak_nxt = peak_q[idx];
		end else begin
			pos_nxt  = pos_q[idx];
			stat_nxt = stat_q[idx];
			err_nxt  = (err_q[idx] == ssiefc_pkg::CNT_MAX) ? err_q[idx] : err_q[idx] + 1'b1;
			peak_nxt = (err_nxt > peak_q[idx]) ? err_nxt : peak_q[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_map_q <= ssiefc_pkg::SELECT_MAP_RST;
			chan_q       <= '0;
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < NUM_ENCODERS; i++) begin
				pos_q[i]  <= '0;
				stat_q[i] <= '0;
				err_q[i]  <= '0;
				peak_q[i] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				select_map_q <= cfg_data;
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
			if (advance) begin
				chan_q      <= chan_nxt;
				pos_q[idx]  <= pos_nxt;
				stat_q[idx] <= stat_nxt;
				err_q[idx]  <= err_nxt;
				peak_q[idx] <= peak_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			frame_s1 <= s_tdata;
		end
		if (advance) begin
			out_data_q <= {(ssiefc_pkg::OUT_W - ssiefc_pkg::DATA_W)'(0), sel_nxt, peak_nxt,
				err_nxt, stat_nxt, pos_nxt, code, chan_q};
		end
	end

	`ASSERT_IMPL(a_chan_range, clk, arst_n, 1'b1, chan_q <= LAST_CH)
	`ASSERT_NEXT(a_advance_loads, clk, arst_n, advance, out_valid_q)
	`ASSERT_IMPL(a_ok_clears, clk, arst_n, out_valid_q && out_data_q[5:3] == ssiefc_pkg::RC_OK, out_data_q[39:24] == '0)
	`ASSERT_IMPL(a_peak_ge_err, clk, arst_n, out_valid_q, out_data_q[55:40] >= out_data_q[39:24])

endmodule
